// ===== src/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// Shared constants for the sorted table binary search block.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 256;

  localparam int ENTRY_W = 32;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

endpackage

`default_nettype wire

// ===== src/sorted_table_binary_search_top.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Sorted table of signed entries with a load command and a binary search.
//
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    tuser: req_type; tdata: index, value, key
// out_     out  out_tvalid/out_tready  tuser: found; tdata: found_index
// cfg_     in   cfg_valid/cfg_ready    cfg_data: count_in_use
//
// A search makes P probes, P <= ceil(log2(count+1)); each probe is a
// memory read state (CHECK) and a compare state (CMP) on the single
// table read port.
// The result register lets a new word in while a result waits.
// Reset clears control and count_in_use; table contents are undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = sts_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output      logic                        in_tready,
  input  wire logic [71:0]                 in_tdata,   // entry_index, entry_value, search_key
  input  wire logic                        in_tuser,   // req_type
  output      logic                        out_tvalid,
  input  wire logic                        out_tready,
  output      logic [7:0]                  out_tdata,  // found_index
  output      logic                        out_tuser,  // found
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [sts_pkg::COUNT_W-1:0] cfg_data
);
  import sts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [COUNT_W-1:0]        count_r;
  logic [CW-1:0]             n_entries;
  logic [INDEX_W-1:0]        entry_index;
  logic signed [ENTRY_W-1:0] entry_value;
  logic signed [ENTRY_W-1:0] search_key;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [ENTRY_W-1:0]        wr_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [ENTRY_W-1:0]        rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count_r <= cfg_data;
    end
  end

  assign n_entries = (32'(count_r) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(count_r);

  assign entry_index = in_tdata[7:0];
  assign entry_value = $signed(in_tdata[39:8]);
  assign search_key  = $signed(in_tdata[71:40]);

  sts_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sts_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .req_type    (in_tuser),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .search_key  (search_key),
    .n_entries   (n_entries),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_found   (out_tuser),
    .out_index   (out_tdata)
  );

endmodule

`default_nettype wire

// ===== src/sts_mem.sv =====
// ----------------------------------------------------------------------------
// sts_mem
// Table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_mem #(
  parameter int TABLE_DEPTH = sts_pkg::DEFAULT_TABLE_DEPTH,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [sts_pkg::ENTRY_W-1:0] wr_data,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output      logic [sts_pkg::ENTRY_W-1:0] rd_data
);
  import sts_pkg::*;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== src/sts_ctrl.sv =====
// ----------------------------------------------------------------------------
// sts_ctrl
// Load decode, binary search sequencer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_ctrl #(
  parameter int TABLE_DEPTH = sts_pkg::DEFAULT_TABLE_DEPTH,
  parameter int AW          = $clog2(TABLE_DEPTH),
  parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic                               req_type,
  input  wire logic [sts_pkg::INDEX_W-1:0]        entry_index,
  input  wire logic signed [sts_pkg::ENTRY_W-1:0] entry_value,
  input  wire logic signed [sts_pkg::ENTRY_W-1:0] search_key,
  input  wire logic [CW-1:0]                      n_entries,
  output      logic                               wr_en,
  output      logic [AW-1:0]                      wr_addr,
  output      logic [sts_pkg::ENTRY_W-1:0]        wr_data,
  output      logic                               rd_en,
  output      logic [AW-1:0]                      rd_addr,
  input  wire logic [sts_pkg::ENTRY_W-1:0]        rd_data,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic                               out_found,
  output      logic [sts_pkg::INDEX_W-1:0]        out_index
);
  import sts_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]                state_r, state_nxt;
  logic [CW-1:0]             lo_r, lo_nxt;
  logic [CW-1:0]             hi_r, hi_nxt;
  logic [AW-1:0]             mid_r, mid_nxt;
  logic signed [ENTRY_W-1:0] key_r, key_nxt;
  logic                      hit_r, hit_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_found_r, out_found_nxt;
  logic [INDEX_W-1:0]        out_index_r, out_index_nxt;

  logic                      accept;
  logic [CW:0]               mid_sum;
  logic [AW-1:0]             mid_calc;
  logic signed [ENTRY_W-1:0] probe;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign probe    = $signed(rd_data);

  assign wr_en   = accept && (req_type == REQ_LOAD) && (32'(entry_index) < TABLE_DEPTH);
  assign wr_addr = AW'(entry_index);
  assign wr_data = entry_value;

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r} - (CW+1)'(1);
  assign mid_calc = AW'(mid_sum >> 1);

  assign rd_en   = (state_r == ST_CHECK) && (lo_r < hi_r);
  assign rd_addr = mid_calc;

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_index_nxt = out_index_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (req_type == REQ_SEARCH)) begin
          lo_nxt    = '0;
          hi_nxt    = n_entries;
          key_nxt   = search_key;
          hit_nxt   = 1'b0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_calc;
          state_nxt = ST_CMP;
        end else begin
          hit_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end
      end
      ST_CMP: begin
        if (key_r < probe) begin
          hi_nxt    = CW'(mid_r);
          state_nxt = ST_CHECK;
        end else if (probe < key_r) begin
          lo_nxt    = CW'(mid_r) + CW'(1);
          state_nxt = ST_CHECK;
        end else begin
          hit_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = hit_r;
          out_index_nxt = hit_r ? INDEX_W'(mid_r) : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    key_r       <= key_nxt;
    hit_r       <= hit_nxt;
    out_found_r <= out_found_nxt;
    out_index_r <= out_index_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_index = out_index_r;

`ifndef ASSERT_OFF
  a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (req_type == REQ_SEARCH) |=> state_r == ST_CHECK)
    else $error("search accepted but sequencer did not start");

  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> $past(rd_en))
    else $error("compare without a read issued the cycle before");

  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK |-> lo_r <= hi_r && hi_r <= n_entries)
    else $error("search bounds out of order");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result raised outside finish state");
`endif

endmodule

`default_nettype wire
